### hw/rtl/pld_pkg.sv
// Shared types and constants for the punycode label decoder.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none
package pld_pkg;

    localparam int CP_W  = 31;
    localparam int ST_W  = 3;
    localparam int DVD_W = 32;
    localparam int DVS_W = 10;

    typedef logic [ST_W-1:0] status_t;
    typedef logic [CP_W-1:0] point_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_BADCHAR  = 3'd1;
    localparam status_t ST_TRUNC    = 3'd2;
    localparam status_t ST_OVERFLOW = 3'd3;
    localparam status_t ST_TOOLONG  = 3'd4;

    localparam logic [7:0]  DASH      = 8'h2D;
    localparam point_t      LIMIT     = 31'h7FFF_FFFF;
    localparam logic [15:0] BASE      = 16'd36;
    localparam logic [4:0]  TMIN      = 5'd1;
    localparam logic [4:0]  TMAX      = 5'd26;
    localparam logic [5:0]  SKEW      = 6'd38;
    localparam logic [15:0] BIAS0     = 16'd72;
    localparam point_t      N0        = 31'd128;
    localparam logic [31:0] DELTA_MAX = 32'd455;

    // reciprocals, product >> 37: x/175 exact for x < 2^29, x/35 exact for x < 2^31
    // (damping by 700 is a shift by 2 followed by the division by 175)
    localparam logic [29:0] RECIP_175 = 30'd785365449;
    localparam logic [31:0] RECIP_35  = 32'd3926827243;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
        logic [DVS_W-1:0]  remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/pld_if.sv
// Request channel interfaces for the label decoder: byte input and code point output.
// Depends on pld_pkg.
`default_nettype none
interface pld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] label_byte;
    logic       end_of_label;

    modport source (output valid, label_byte, end_of_label, input ready);
    modport sink   (input valid, label_byte, end_of_label, output ready);
endinterface

interface pld_out_if;
    logic              valid;
    logic              ready;
    pld_pkg::point_t   code_point;
    logic              point_valid;
    pld_pkg::status_t  status;
    logic              final_result;

    modport source (output valid, code_point, point_valid, status, final_result, input ready);
    modport sink   (input valid, code_point, point_valid, status, final_result, output ready);
endinterface
`default_nettype wire

### hw/rtl/punycode_label_decoder_unit.sv
// Punycode (RFC 3492) label decoder, top level.
// Depends on pld_pkg, pld_if, pld_ram and pld_div.
//
// Usage:
//   byte_in   : one request per label byte (label_byte, end_of_label). Bytes are
//               taken one per cycle while the block is loading a label.
//   point_out : result requests, one per decoded code point in output order, or
//               a single request with point_valid 0 carrying an error status or
//               marking an empty label. final_result flags the last one.
// Decoding:
//   After the last byte, byte_in is held off while decoding runs: each basic
//   code point is read and written back, each digit is read and evaluated,
//   each decoded point takes three divisions on the shared bit-serial divider
//   plus bookkeeping and the bias scaling steps, and the insertion moves
//   entries one at a time through the point memory. Emission reads each
//   code point and loads it into the output register.
// Reset: clears the label state; no memory clearing pass is needed.
// Stall: results sit in an output register; the sequencer waits while it is
//   full and not taken. The next label may load while the last result waits.
`default_nettype none
module punycode_label_decoder_unit #(
    parameter int MAX_LABEL_BYTES = 64
) (
    input wire logic  clk,
    input wire logic  rst_n,
    pld_in_if.sink    byte_in,
    pld_out_if.source point_out
);
    localparam int CW = $clog2(MAX_LABEL_BYTES + 1);
    localparam int AW = $clog2(MAX_LABEL_BYTES);

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_BAS_RD   = 5'd1;
    localparam logic [4:0] S_BAS_WR   = 5'd2;
    localparam logic [4:0] S_INT      = 5'd3;
    localparam logic [4:0] S_DIG_RD   = 5'd4;
    localparam logic [4:0] S_DIG_EX   = 5'd5;
    localparam logic [4:0] S_DAMP     = 5'd6;
    localparam logic [4:0] S_LEN      = 5'd8;
    localparam logic [4:0] S_LEN_W    = 5'd9;
    localparam logic [4:0] S_LOOP     = 5'd10;
    localparam logic [4:0] S_FIN      = 5'd12;
    localparam logic [4:0] S_FIN_W    = 5'd13;
    localparam logic [4:0] S_NDIV     = 5'd14;
    localparam logic [4:0] S_NDIV_W   = 5'd15;
    localparam logic [4:0] S_SH_RD    = 5'd16;
    localparam logic [4:0] S_SH_WR    = 5'd17;
    localparam logic [4:0] S_INS      = 5'd18;
    localparam logic [4:0] S_EM_RD    = 5'd19;
    localparam logic [4:0] S_EM_LD    = 5'd20;
    localparam logic [4:0] S_ERR      = 5'd21;

    // digit value: bit 6 set when the byte is a base-36 digit
    function automatic logic [6:0] digit_of(input logic [7:0] b);
        logic [6:0] r;
        r = '0;
        if (b >= 8'h61 && b <= 8'h7A)
        begin
            r = {1'b1, 6'(b - 8'h61)};
        end
        else if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = {1'b1, 6'(b - 8'h41)};
        end
        else if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, 6'(b - 8'h30 + 8'd26)};
        end
        return r;
    endfunction

    logic [4:0]             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   dash_seen_reg, dash_seen_next;
    logic [CW-1:0]          dash_pos_reg, dash_pos_next;
    pld_pkg::status_t       err_reg, err_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [CW-1:0]          pc_reg, pc_next;
    logic [CW-1:0]          pos_reg, pos_next;
    pld_pkg::point_t        i_reg, i_next;
    pld_pkg::point_t        old_reg, old_next;
    pld_pkg::point_t        w_reg, w_next;
    logic [15:0]            k_reg, k_next;
    logic [15:0]            bias_reg, bias_next;
    pld_pkg::point_t        n_reg, n_next;
    logic [31:0]            dl_reg, dl_next;
    logic [15:0]            kb_reg, kb_next;
    logic                   ov_reg, ov_next;
    pld_pkg::point_t        ocp_reg, ocp_next;
    logic                   opv_reg, opv_next;
    pld_pkg::status_t       ost_reg, ost_next;
    logic                   ofin_reg, ofin_next;

    // memory ports
    logic                   b_we, b_re;
    logic [AW-1:0]          b_wa, b_ra;
    logic [7:0]             b_rd;
    logic                   p_we, p_re;
    logic [AW-1:0]          p_wa, p_ra;
    pld_pkg::point_t        p_wd, p_rd;

    pld_pkg::div_req_t      dreq;
    pld_pkg::div_rsp_t      drsp;

    // datapath helpers
    logic                   in_acc, slot_free;
    logic [6:0]             dig;
    logic [36:0]            prod;
    logic [37:0]            sum;
    logic [4:0]             t;
    logic [36:0]            wprod;
    logic [CW-1:0]          len;
    pld_pkg::point_t        delta;
    logic [58:0]            damp_prod;
    logic [62:0]            scale_prod;

    pld_ram #(.WIDTH(8), .DEPTH(MAX_LABEL_BYTES)) u_byte_ram (
        .clk(clk), .wr_en(b_we), .wr_addr(b_wa), .wr_data(byte_in.label_byte),
        .rd_en(b_re), .rd_addr(b_ra), .rd_data(b_rd)
    );

    pld_ram #(.WIDTH(pld_pkg::CP_W), .DEPTH(MAX_LABEL_BYTES)) u_point_ram (
        .clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
        .rd_en(p_re), .rd_addr(p_ra), .rd_data(p_rd)
    );

    pld_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign byte_in.ready = (state_reg == S_LOAD);
    assign in_acc        = byte_in.valid && byte_in.ready;
    assign slot_free     = !ov_reg || point_out.ready;

    assign len   = pc_reg + CW'(1);
    assign delta = i_reg - old_reg;
    assign dig   = digit_of(b_rd);
    assign prod  = dig[5:0] * w_reg;
    assign sum   = {7'd0, i_reg} + {1'b0, prod};
    assign wprod = w_reg * (6'd36 - {1'b0, t});

    // constant divisions of the bias adaptation: delta/700 and dl/35
    assign damp_prod  = delta[pld_pkg::CP_W-1:2] * pld_pkg::RECIP_175;
    assign scale_prod = dl_reg[30:0] * pld_pkg::RECIP_35;

    // threshold t from k and bias
    always_comb
    begin
        if (k_reg <= bias_reg)
        begin
            t = pld_pkg::TMIN;
        end
        else if (k_reg >= bias_reg + 16'(pld_pkg::TMAX))
        begin
            t = pld_pkg::TMAX;
        end
        else
        begin
            t = 5'(k_reg - bias_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dash_seen_next = dash_seen_reg;
        dash_pos_next  = dash_pos_reg;
        err_next       = err_reg;
        j_next         = j_reg;
        pc_next        = pc_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        old_next       = old_reg;
        w_next         = w_reg;
        k_next         = k_reg;
        bias_next      = bias_reg;
        n_next         = n_reg;
        dl_next        = dl_reg;
        kb_next        = kb_reg;
        ov_next        = ov_reg && !point_out.ready;
        ocp_next       = ocp_reg;
        opv_next       = opv_reg;
        ost_next       = ost_reg;
        ofin_next      = ofin_reg;

        b_we = 1'b0;
        b_wa = cnt_reg[AW-1:0];
        b_re = 1'b0;
        b_ra = pos_reg[AW-1:0];
        p_we = 1'b0;
        p_wa = j_reg[AW-1:0];
        p_wd = {23'd0, b_rd};
        p_re = 1'b0;
        p_ra = j_reg[AW-1:0];

        dreq.start    = 1'b0;
        dreq.dividend = {1'b0, delta};
        dreq.divisor  = pld_pkg::DVS_W'(len);

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < CW'(MAX_LABEL_BYTES))
                    begin
                        b_we = 1'b1;
                        if (byte_in.label_byte == pld_pkg::DASH)
                        begin
                            dash_seen_next = 1'b1;
                            dash_pos_next  = cnt_reg;
                        end
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        err_next = pld_pkg::ST_TOOLONG;
                    end
                    if (byte_in.end_of_label)
                    begin
                        j_next  = '0;
                        pc_next = '0;
                        if (cnt_reg >= CW'(MAX_LABEL_BYTES) || err_reg != pld_pkg::ST_OK)
                        begin
                            state_next = S_ERR;
                        end
                        else
                        begin
                            state_next = S_BAS_RD;
                        end
                    end
                end
            end
            S_BAS_RD:
            begin
                if (dash_seen_reg && j_reg < dash_pos_reg)
                begin
                    b_re       = 1'b1;
                    b_ra       = j_reg[AW-1:0];
                    state_next = S_BAS_WR;
                end
                else
                begin
                    pos_next   = dash_seen_reg ? dash_pos_reg + CW'(1) : '0;
                    i_next     = '0;
                    n_next     = pld_pkg::N0;
                    bias_next  = pld_pkg::BIAS0;
                    state_next = S_INT;
                end
            end
            S_BAS_WR:
            begin
                if (b_rd[7])
                begin
                    err_next   = pld_pkg::ST_BADCHAR;
                    state_next = S_ERR;
                end
                else
                begin
                    p_we       = 1'b1;
                    j_next     = j_reg + CW'(1);
                    pc_next    = pc_reg + CW'(1);
                    state_next = S_BAS_RD;
                end
            end
            S_INT:
            begin
                if (pos_reg < cnt_reg)
                begin
                    old_next   = i_reg;
                    w_next     = 31'd1;
                    k_next     = pld_pkg::BASE;
                    state_next = S_DIG_RD;
                end
                else if (pc_reg == '0)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_EM_RD;
                end
            end
            S_DIG_RD:
            begin
                if (pos_reg >= cnt_reg)
                begin
                    err_next   = pld_pkg::ST_TRUNC;
                    state_next = S_ERR;
                end
                else
                begin
                    b_re       = 1'b1;
                    state_next = S_DIG_EX;
                end
            end
            S_DIG_EX:
            begin
                pos_next = pos_reg + CW'(1);
                if (!dig[6])
                begin
                    err_next   = pld_pkg::ST_BADCHAR;
                    state_next = S_ERR;
                end
                else if (sum > {7'd0, pld_pkg::LIMIT})
                begin
                    err_next   = pld_pkg::ST_OVERFLOW;
                    state_next = S_ERR;
                end
                else
                begin
                    i_next = sum[pld_pkg::CP_W-1:0];
                    if (dig[5:0] < {1'b0, t})
                    begin
                        state_next = S_DAMP;
                    end
                    else if (wprod > {6'd0, pld_pkg::LIMIT})
                    begin
                        err_next   = pld_pkg::ST_OVERFLOW;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        w_next     = wprod[pld_pkg::CP_W-1:0];
                        k_next     = k_reg + pld_pkg::BASE;
                        state_next = S_DIG_RD;
                    end
                end
            end
            // bias adaptation
            S_DAMP:
            begin
                if (old_reg == '0)
                begin
                    dl_next = {10'd0, damp_prod[58:37]};
                end
                else
                begin
                    dl_next = {2'd0, delta[pld_pkg::CP_W-1:1]};
                end
                state_next = S_LEN;
            end
            S_LEN:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = dl_reg;
                state_next    = S_LEN_W;
            end
            S_LEN_W:
            begin
                if (drsp.done)
                begin
                    dl_next    = dl_reg + drsp.quotient;
                    kb_next    = '0;
                    state_next = S_LOOP;
                end
            end
            // one scaling step per cycle; dl stays below 2^31 here
            S_LOOP:
            begin
                if (dl_reg > pld_pkg::DELTA_MAX)
                begin
                    dl_next = {6'd0, scale_prod[62:37]};
                    kb_next = kb_reg + pld_pkg::BASE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // dl is at most 455 here
                dreq.start    = 1'b1;
                dreq.dividend = 32'({6'd0, dl_reg[9:0]} * 16'd36);
                dreq.divisor  = dl_reg[9:0] + 10'(pld_pkg::SKEW);
                state_next    = S_FIN_W;
            end
            S_FIN_W:
            begin
                if (drsp.done)
                begin
                    bias_next  = kb_reg + drsp.quotient[15:0];
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = {1'b0, i_reg};
                state_next    = S_NDIV_W;
            end
            S_NDIV_W:
            begin
                if (drsp.done)
                begin
                    if (drsp.quotient > {1'b0, pld_pkg::LIMIT - n_reg})
                    begin
                        err_next   = pld_pkg::ST_OVERFLOW;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        n_next     = n_reg + drsp.quotient[pld_pkg::CP_W-1:0];
                        i_next     = pld_pkg::CP_W'(drsp.remainder);
                        j_next     = pc_reg;
                        state_next = S_SH_RD;
                    end
                end
            end
            // open a slot at i by moving entries up one place
            S_SH_RD:
            begin
                if ({{(pld_pkg::CP_W-CW){1'b0}}, j_reg} > i_reg)
                begin
                    p_re       = 1'b1;
                    p_ra       = AW'(j_reg - CW'(1));
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_SH_WR:
            begin
                p_we       = 1'b1;
                p_wd       = p_rd;
                j_next     = j_reg - CW'(1);
                state_next = S_SH_RD;
            end
            S_INS:
            begin
                p_we       = 1'b1;
                p_wa       = i_reg[AW-1:0];
                p_wd       = n_reg;
                pc_next    = pc_reg + CW'(1);
                i_next     = i_reg + 31'd1;
                state_next = S_INT;
            end
            S_EM_RD:
            begin
                p_re       = 1'b1;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    ocp_next  = p_rd;
                    opv_next  = 1'b1;
                    ost_next  = pld_pkg::ST_OK;
                    ofin_next = (j_reg + CW'(1) == pc_reg);
                    if (j_reg + CW'(1) == pc_reg)
                    begin
                        cnt_next       = '0;
                        dash_seen_next = 1'b0;
                        dash_pos_next  = '0;
                        err_next       = pld_pkg::ST_OK;
                        state_next     = S_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_EM_RD;
                    end
                end
            end
            S_ERR:
            begin
                // error, or a label with nothing decoded (status ok)
                if (slot_free)
                begin
                    ov_next        = 1'b1;
                    ocp_next       = '0;
                    opv_next       = 1'b0;
                    ost_next       = err_reg;
                    ofin_next      = 1'b1;
                    cnt_next       = '0;
                    dash_seen_next = 1'b0;
                    dash_pos_next  = '0;
                    err_next       = pld_pkg::ST_OK;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            dash_seen_reg <= 1'b0;
            dash_pos_reg  <= '0;
            err_reg       <= pld_pkg::ST_OK;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dash_seen_reg <= dash_seen_next;
            dash_pos_reg  <= dash_pos_next;
            err_reg       <= err_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        pc_reg   <= pc_next;
        pos_reg  <= pos_next;
        i_reg    <= i_next;
        old_reg  <= old_next;
        w_reg    <= w_next;
        k_reg    <= k_next;
        bias_reg <= bias_next;
        n_reg    <= n_next;
        dl_reg   <= dl_next;
        kb_reg   <= kb_next;
        ocp_reg  <= ocp_next;
        opv_reg  <= opv_next;
        ost_reg  <= ost_next;
        ofin_reg <= ofin_next;
    end

    assign point_out.valid        = ov_reg;
    assign point_out.code_point   = ocp_reg;
    assign point_out.point_valid  = opv_reg;
    assign point_out.status       = ost_reg;
    assign point_out.final_result = ofin_reg;
endmodule
`default_nettype wire

### hw/rtl/pld_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module pld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/pld_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pld_pkg.
`default_nettype none
module pld_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pld_pkg::div_req_t req,
    output pld_pkg::div_rsp_t      rsp
);
    localparam int CNT_W = $clog2(pld_pkg::DVD_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [pld_pkg::DVD_W-1:0] q_reg, q_next;
    logic [pld_pkg::DVS_W-1:0] r_reg, r_next;
    logic [pld_pkg::DVS_W-1:0] d_reg, d_next;
    logic [pld_pkg::DVS_W:0]   r_shift;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        r_shift   = {r_reg, q_reg[pld_pkg::DVD_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            if (r_shift >= {1'b0, d_reg})
            begin
                r_next = pld_pkg::DVS_W'(r_shift - {1'b0, d_reg});
                q_next = {q_reg[pld_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_shift[pld_pkg::DVS_W-1:0];
                q_next = {q_reg[pld_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(pld_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;
endmodule
`default_nettype wire
